### hw/rtl/assert_macros.svh
// Assertion macros for the port checker module of the encoder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property at each rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### hw/rtl/b64u_pkg.sv
// Shared types and the sextet-to-ASCII mapping for the base64url encoder.
// Depends on nothing.
package b64u_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned SextetWidth = 6;
   localparam int unsigned CharWidth   = 7;
   localparam int unsigned CarryWidth  = 4;

   typedef logic [SextetWidth-1:0] sextet_type;
   typedef logic [CharWidth-1:0]   ascii_type;

   localparam ascii_type CharUpperA = 7'd65;
   localparam ascii_type CharLowerA = 7'd97;
   localparam ascii_type CharZero   = 7'd48;
   localparam ascii_type CharDash   = 7'd45;
   localparam ascii_type CharUnder  = 7'd95;

   function automatic ascii_type encode_sextet(sextet_type s);
      ascii_type c;
      case (s) inside
         [6'd0:6'd25]:  c = ascii_type'(CharUpperA + ascii_type'(s));
         [6'd26:6'd51]: c = ascii_type'(CharLowerA + ascii_type'(s) - 7'd26);
         [6'd52:6'd61]: c = ascii_type'(CharZero + ascii_type'(s) - 7'd52);
         6'd62:         c = CharDash;
         default:       c = CharUnder;
      endcase
      return c;
   endfunction

endpackage

### hw/rtl/base64url_stream_encoder.sv
// Channel   Direction  Handshake           Payload
// req       in         req_valid/stall     req_data_byte[7:0], req_last_byte
// rsp       out        rsp_valid/stall     rsp_out_char[6:0], rsp_last_char
//
// Each accepted byte is encoded in the cycle of its transfer; its one or two
// characters appear in the next cycle from a two-entry result register.
// A byte is taken every cycle while rsp is not stalled; a byte that yields two
// characters (third of a group, or a last byte) holds off the next byte until
// its first character has been taken.
// A rsp stall holds off req in the same cycle once a character is waiting.
// Synchronous active-high reset clears the group phase, carry and result count.
// Depends on b64u_pkg.
module base64url_stream_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [b64u_pkg::ByteWidth-1:0]    req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output b64u_pkg::ascii_type               rsp_out_char,
   output logic                              rsp_last_char
);

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   phase_type                             phase_ff, phase_in;
   logic [b64u_pkg::CarryWidth-1:0]       carry_ff, carry_in;
   logic [1:0]                            count_ff;
   b64u_pkg::ascii_type                   char0_ff, char1_ff;
   logic                                  last0_ff, last1_ff;

   b64u_pkg::sextet_type                  sext0, sext1;
   logic                                  two_chars;
   logic                                  second_last;
   logic                                  req_xfer, rsp_xfer;

   assign rsp_valid     = (count_ff != 2'd0);
   assign rsp_out_char  = char0_ff;
   assign rsp_last_char = last0_ff;
   assign rsp_xfer      = rsp_valid && !rsp_stall;
   assign req_stall     = !((count_ff == 2'd0) || ((count_ff == 2'd1) && !rsp_stall));
   assign req_xfer      = req_valid && !req_stall;

   always_comb begin
      sext0       = req_data_byte[7:2];
      sext1       = {req_data_byte[1:0], 4'b0000};
      two_chars   = req_last_byte;
      second_last = 1'b1;
      phase_in    = PH_SECOND;
      carry_in    = {2'b00, req_data_byte[1:0]};
      case (phase_ff)
         PH_SECOND: begin
            sext0       = {carry_ff[1:0], req_data_byte[7:4]};
            sext1       = {req_data_byte[3:0], 2'b00};
            two_chars   = req_last_byte;
            second_last = 1'b1;
            phase_in    = PH_THIRD;
            carry_in    = req_data_byte[3:0];
         end
         PH_THIRD: begin
            sext0       = {carry_ff, req_data_byte[7:6]};
            sext1       = req_data_byte[5:0];
            two_chars   = 1'b1;
            second_last = req_last_byte;
            phase_in    = PH_FIRST;
            carry_in    = '0;
         end
         default: begin
         end
      endcase
      if (req_last_byte) begin
         phase_in = PH_FIRST;
         carry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         carry_ff <= '0;
         count_ff <= 2'd0;
      end else if (req_xfer) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
         count_ff <= two_chars ? 2'd2 : 2'd1;
         char0_ff <= b64u_pkg::encode_sextet(sext0);
         last0_ff <= 1'b0;
         char1_ff <= b64u_pkg::encode_sextet(sext1);
         last1_ff <= second_last;
      end else if (rsp_xfer) begin
         count_ff <= count_ff - 2'd1;
         char0_ff <= char1_ff;
         last0_ff <= last1_ff;
      end
   end

endmodule

### hw/rtl/b64u_checker.sv
// Port-level checks for base64url_stream_encoder, bound into that module.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module b64u_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_char
);

   logic       char_ok;
   logic       rsp_hold;
   logic [7:0] rsp_word;

   assign char_ok  = rsp_out_char inside {[7'd65:7'd90], [7'd97:7'd122], [7'd48:7'd57],
                                          7'd45, 7'd95};
   assign rsp_hold = rsp_valid && rsp_stall;
   assign rsp_word = {rsp_out_char, rsp_last_char};

   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)
   `ASSERT_CLK(a_req_gives_rsp, clock, reset, (req_valid && !req_stall) |=> rsp_valid)
   `ASSERT_CLK(a_char_legal, clock, reset, rsp_valid |-> char_ok)
   `ASSERT_CLK(a_rsp_holds, clock, reset, rsp_hold |=> (rsp_valid && $stable(rsp_word)))

endmodule

bind base64url_stream_encoder b64u_port_checker u_b64u_port_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_char  (rsp_out_char),
   .rsp_last_char (rsp_last_char)
);

### tb/sv/b64u_checker.sv
// Scoreboard for the base64url stream encoder: tracks byte transfers, predicts
// the characters each one yields and compares them with the result transfers.
// Depends on b64u_pkg for the sextet and character types.
module b64u_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [6:0] rsp_out_char,
   input  logic       rsp_last_char,
   output int         fail_count,
   output int         pending_chars,
   output int         chars_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {GRP_FIRST, GRP_SECOND, GRP_THIRD, GRP_UNUSED} group_pos_type;

   typedef struct packed {
      b64u_pkg::ascii_type code;
      logic                final_char;
   } enc_char_type;

   localparam string Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   group_pos_type       group_pos;
   logic [3:0]          held_bits;
   enc_char_type        char_queue[$];

   function automatic b64u_pkg::ascii_type to_ascii(b64u_pkg::sextet_type s);
      return b64u_pkg::ascii_type'(Alphabet[s]);
   endfunction

   function automatic void queue_char(b64u_pkg::sextet_type s, logic fin);
      enc_char_type c;
      c.code       = to_ascii(s);
      c.final_char = fin;
      char_queue.push_back(c);
   endfunction

   function automatic void encode_byte(logic [7:0] b, logic fin);
      case (group_pos)
         GRP_SECOND: begin
            queue_char({held_bits[1:0], b[7:4]}, 1'b0);
            if (fin) begin
               queue_char({b[3:0], 2'b00}, 1'b1);
               group_pos = GRP_FIRST;
               held_bits = '0;
            end else begin
               held_bits = b[3:0];
               group_pos = GRP_THIRD;
            end
         end
         GRP_THIRD: begin
            queue_char({held_bits, b[7:6]}, 1'b0);
            queue_char(b[5:0], fin);
            group_pos = GRP_FIRST;
            held_bits = '0;
         end
         default: begin
            queue_char(b[7:2], 1'b0);
            if (fin) begin
               queue_char({b[1:0], 4'b0000}, 1'b1);
               group_pos = GRP_FIRST;
               held_bits = '0;
            end else begin
               held_bits = {2'b00, b[1:0]};
               group_pos = GRP_SECOND;
            end
         end
      endcase
   endfunction

   initial begin
      fail_count    = 0;
      pending_chars = 0;
      chars_checked = 0;
      group_pos     = GRP_FIRST;
      held_bits     = '0;
   end

   always @(posedge clock) begin
      enc_char_type want;
      if (reset) begin
         group_pos = GRP_FIRST;
         held_bits = '0;
      end else begin
         if (req_valid && !req_stall)
            encode_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (char_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected character, expected none, got %0d last %0d",
                        $time, rsp_out_char, rsp_last_char);
            end else begin
               want = char_queue.pop_front();
               if (rsp_out_char !== want.code) begin
                  fail_count++;
                  $display("%0t: out_char mismatch, expected %0d, got %0d",
                           $time, want.code, rsp_out_char);
               end
               if (rsp_last_char !== want.final_char) begin
                  fail_count++;
                  $display("%0t: last_char mismatch, expected %0d, got %0d",
                           $time, want.final_char, rsp_last_char);
               end
            end
         end
      end
      pending_chars = char_queue.size();
   end

endmodule

### tb/sv/tb_top.sv
// Stimulus and verdict for the base64url stream encoder: directed and random
// byte messages with random idling on both sides; checking in b64u_checker.
// Depends on b64u_pkg, base64url_stream_encoder and b64u_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBytes   = 1300;
   localparam int QuietAfter    = 1150;
   localparam int HoldCycles    = 80;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 8;
   localparam int DirectedLen   = 22;

   // {last, byte}
   localparam logic [8:0] Directed [DirectedLen] = '{
      9'h100, 9'h1ff,
      9'h0ff, 9'h1ff,
      9'h0ff, 9'h0ff, 9'h1ff,
      9'h000, 9'h000, 9'h000, 9'h100,
      9'h0fb, 9'h0ef, 9'h1be,
      9'h068, 9'h0cf, 9'h034, 9'h1f4,
      9'h0ff, 9'h000, 9'h0aa, 9'h155
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [6:0] rsp_out_char;
   logic       rsp_last_char;

   int fail_count;
   int pending_chars;
   int chars_checked;
   int bytes_sent     = 0;
   int messages_sent  = 0;
   int idle_cycles    = 0;
   bit quiet          = 1'b0;

   always #1 clock = ~clock;

   base64url_stream_encoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   b64u_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .fail_count    (fail_count),
      .pending_chars (pending_chars),
      .chars_checked (chars_checked)
   );

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
      if (fin) messages_sent++;
      if (bytes_sent >= QuietAfter) quiet = 1'b1;
   endtask

   // byte source
   initial begin
      int len;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < DirectedLen; i++)
         send_byte(Directed[i][7:0], Directed[i][8]);
      while (bytes_sent < RandomBytes) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
      req_valid <= 1'b0;
      while (pending_chars != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      $display("covered %0d bytes in %0d messages, all group positions ended as last",
               bytes_sent, messages_sent);
      $display("compared %0d characters, %0d mismatches", chars_checked, fail_count);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // result sink: one long hold-off, then random stall bursts until quiet
   initial begin
      rsp_stall <= 1'b0;
      wait (bytes_sent >= DirectedLen + 40);
      @(negedge clock);
      rsp_stall <= 1'b1;
      repeat (HoldCycles) @(negedge clock);
      rsp_stall <= 1'b0;
      while (!quiet) begin
         @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("timeout after %0d cycles without a transfer", idle_cycles);
         $display("tb_top failed");
         $finish;
      end
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/b64u_pkg.sv
hw/rtl/base64url_stream_encoder.sv
hw/rtl/b64u_checker.sv
tb/sv/b64u_checker.sv
tb/sv/tb_top.sv
